// ===== design/hcrp_pkg.sv =====
// Shared types, codes and helpers of the HEVC configuration record parser.
// No dependencies; every other design file imports this package.
`default_nettype none

package hcrp_pkg;

    // Shortest record that can hold the fixed header.
    localparam logic [15:0] MIN_RECORD_BYTES = 16'd23;

    // Queue between the parsing front and the result back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Most results that one byte can cause.
    localparam int MAX_RESULTS = 4;

    typedef enum logic [2:0] {
        EV_FIELD  = 3'd0,
        EV_UNIT   = 3'd1,
        EV_DONE   = 3'd2,
        EV_SHORT  = 3'd3,
        EV_COUNT  = 3'd4,
        EV_LENGTH = 3'd5,
        EV_TRUNC  = 3'd6
    } t_event;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_ARRAY   = 3'd2,
        PH_CNT_HI  = 3'd3,
        PH_CNT_LO  = 3'd4,
        PH_LEN_HI  = 3'd5,
        PH_LEN_LO  = 3'd6,
        PH_PAYLOAD = 3'd7
    } t_phase;

    // Header field indices in record order.
    localparam logic [4:0] FID_VERSION       = 5'd0;
    localparam logic [4:0] FID_PROFILE_SPACE = 5'd1;
    localparam logic [4:0] FID_TIER_FLAG     = 5'd2;
    localparam logic [4:0] FID_PROFILE_IDC   = 5'd3;
    localparam logic [4:0] FID_COMPAT_FLAGS  = 5'd4;
    localparam logic [4:0] FID_CONSTR_FLAGS  = 5'd5;
    localparam logic [4:0] FID_LEVEL_IDC     = 5'd6;
    localparam logic [4:0] FID_MIN_SPATIAL   = 5'd7;
    localparam logic [4:0] FID_PARALLELISM   = 5'd8;
    localparam logic [4:0] FID_CHROMA_FORMAT = 5'd9;
    localparam logic [4:0] FID_DEPTH_LUMA    = 5'd10;
    localparam logic [4:0] FID_DEPTH_CHROMA  = 5'd11;
    localparam logic [4:0] FID_AVG_RATE      = 5'd12;
    localparam logic [4:0] FID_CONST_RATE    = 5'd13;
    localparam logic [4:0] FID_NUM_TEMPORAL  = 5'd14;
    localparam logic [4:0] FID_TEMP_NESTED   = 5'd15;
    localparam logic [4:0] FID_LENGTH_SIZE   = 5'd16;
    localparam logic [4:0] FID_NUM_ARRAYS    = 5'd17;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_record;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [4:0]  field_id;
        logic [47:0] field_value;
        logic [5:0]  unit_type;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic        last;
    } t_res;

    // All results of one byte, in order; the final one carries last.
    typedef t_res [MAX_RESULTS-1:0] t_bundle;

    function automatic t_res mk_field(logic [4:0] id, logic [47:0] val);
        t_res r;
        r             = '0;
        r.event_res   = EV_FIELD;
        r.field_id    = id;
        r.field_value = val;
        return r;
    endfunction

    function automatic t_res mk_event(t_event ev);
        t_res r;
        r           = '0;
        r.event_res = ev;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/hcrp_front.sv =====
// Parsing front: walks the record one byte per accepted request and builds
// the bundle of results for that byte. Depends on hcrp_pkg.
`default_nettype none

module hcrp_front
    import hcrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [15:0] i_record_length,
    input  wire logic        i_accept,
    input  wire t_in_req     i_req,
    output logic             o_push,
    output t_bundle          o_bundle
);

    t_phase      r_phase, n_phase;
    logic        r_halted, n_halted;
    logic [15:0] r_pos, n_pos;
    logic [47:0] r_acc, n_acc;
    logic [7:0]  r_arrays, n_arrays;
    logic [15:0] r_units, n_units;
    logic [5:0]  r_utype, n_utype;
    logic [15:0] r_payload, n_payload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_halted  <= 1'b1;
            r_pos     <= '0;
            r_acc     <= '0;
            r_arrays  <= '0;
            r_units   <= '0;
            r_utype   <= '0;
            r_payload <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_halted  <= n_halted;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_arrays  <= n_arrays;
            r_units   <= n_units;
            r_utype   <= n_utype;
            r_payload <= n_payload;
        end
    end

    always_comb begin
        logic [7:0]  b;
        logic [15:0] cur;
        logic [15:0] nxt;
        logic [15:0] remaining;
        logic [15:0] len;
        logic [47:0] acc_sh;
        logic        short_rec;
        logic        done_field;
        logic        do_next;
        logic        do_end;
        logic [2:0]  cnt;
        logic [2:0]  last_ix;
        t_bundle     slots;

        b          = i_req.data_byte;
        cur        = r_pos;
        nxt        = r_pos + 16'd1;
        remaining  = '0;
        len        = '0;
        acc_sh     = '0;
        short_rec  = 1'b0;
        done_field = 1'b0;
        do_next    = 1'b0;
        do_end     = 1'b0;
        cnt        = '0;
        last_ix    = '0;
        slots      = '0;

        n_phase   = r_phase;
        n_halted  = r_halted;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_arrays  = r_arrays;
        n_units   = r_units;
        n_utype   = r_utype;
        n_payload = r_payload;

        if (i_req.start_of_record) begin
            n_pos     = '0;
            n_acc     = '0;
            n_arrays  = '0;
            n_units   = '0;
            n_utype   = '0;
            n_payload = '0;
            n_halted  = 1'b0;
            n_phase   = PH_HEADER;
            if (i_record_length < MIN_RECORD_BYTES) begin
                short_rec = 1'b1;
                slots[0]  = mk_event(EV_SHORT);
                cnt       = 3'd1;
                n_halted  = 1'b1;
                n_phase   = PH_IDLE;
            end
        end

        if (!short_rec && !n_halted) begin
            cur       = n_pos;
            nxt       = n_pos + 16'd1;
            n_pos     = nxt;
            remaining = (i_record_length > nxt) ? (i_record_length - nxt) : 16'd0;

            case (n_phase)
                PH_HEADER: begin
                    acc_sh     = {n_acc[39:0], b};
                    n_acc      = acc_sh;
                    done_field = 1'b1;
                    case (cur)
                        16'd0: begin
                            slots[0] = mk_field(FID_VERSION, {40'd0, b});
                            cnt      = 3'd1;
                        end
                        16'd1: begin
                            slots[0] = mk_field(FID_PROFILE_SPACE, {46'd0, b[7:6]});
                            slots[1] = mk_field(FID_TIER_FLAG, {47'd0, b[5]});
                            slots[2] = mk_field(FID_PROFILE_IDC, {43'd0, b[4:0]});
                            cnt      = 3'd3;
                        end
                        16'd5: begin
                            slots[0] = mk_field(FID_COMPAT_FLAGS, {16'd0, acc_sh[31:0]});
                            cnt      = 3'd1;
                        end
                        16'd11: begin
                            slots[0] = mk_field(FID_CONSTR_FLAGS, acc_sh);
                            cnt      = 3'd1;
                        end
                        16'd12: begin
                            slots[0] = mk_field(FID_LEVEL_IDC, {40'd0, b});
                            cnt      = 3'd1;
                        end
                        16'd14: begin
                            slots[0] = mk_field(FID_MIN_SPATIAL, {36'd0, acc_sh[11:0]});
                            cnt      = 3'd1;
                        end
                        16'd15: begin
                            slots[0] = mk_field(FID_PARALLELISM, {46'd0, b[1:0]});
                            cnt      = 3'd1;
                        end
                        16'd16: begin
                            slots[0] = mk_field(FID_CHROMA_FORMAT, {46'd0, b[1:0]});
                            cnt      = 3'd1;
                        end
                        16'd17: begin
                            slots[0] = mk_field(FID_DEPTH_LUMA, {45'd0, b[2:0]});
                            cnt      = 3'd1;
                        end
                        16'd18: begin
                            slots[0] = mk_field(FID_DEPTH_CHROMA, {45'd0, b[2:0]});
                            cnt      = 3'd1;
                        end
                        16'd20: begin
                            slots[0] = mk_field(FID_AVG_RATE, {32'd0, acc_sh[15:0]});
                            cnt      = 3'd1;
                        end
                        16'd21: begin
                            slots[0] = mk_field(FID_CONST_RATE, {46'd0, b[7:6]});
                            slots[1] = mk_field(FID_NUM_TEMPORAL, {45'd0, b[5:3]});
                            slots[2] = mk_field(FID_TEMP_NESTED, {47'd0, b[2]});
                            slots[3] = mk_field(FID_LENGTH_SIZE, {46'd0, b[1:0]});
                            cnt      = 3'd4;
                        end
                        16'd22: begin
                            slots[0] = mk_field(FID_NUM_ARRAYS, {40'd0, b});
                            cnt      = 3'd1;
                            n_arrays = b;
                            if (b == 8'd0) begin
                                slots[1] = mk_event(EV_DONE);
                                cnt      = 3'd2;
                                n_halted = 1'b1;
                                n_phase  = PH_IDLE;
                            end else begin
                                n_phase = PH_ARRAY;
                            end
                        end
                        default: begin
                            done_field = 1'b0;
                        end
                    endcase
                    if (done_field) begin
                        n_acc = '0;
                    end
                end
                PH_ARRAY: begin
                    n_utype = b[5:0];
                    n_phase = PH_CNT_HI;
                end
                PH_CNT_HI: begin
                    n_acc   = {40'd0, b};
                    n_phase = PH_CNT_LO;
                end
                PH_CNT_LO: begin
                    n_units = {n_acc[7:0], b};
                    n_acc   = '0;
                    if (remaining < n_units) begin
                        slots[0] = mk_event(EV_COUNT);
                        cnt      = 3'd1;
                        n_halted = 1'b1;
                        n_phase  = PH_IDLE;
                    end else if (n_units == 16'd0) begin
                        do_end = 1'b1;
                    end else begin
                        n_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    n_acc   = {40'd0, b};
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    len   = {n_acc[7:0], b};
                    n_acc = '0;
                    if (remaining < len) begin
                        slots[0] = mk_event(EV_LENGTH);
                        cnt      = 3'd1;
                        n_halted = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        slots[0]                = mk_event(EV_UNIT);
                        slots[0].unit_type      = n_utype;
                        slots[0].payload_offset = nxt;
                        slots[0].payload_length = len;
                        cnt                     = 3'd1;
                        n_units                 = n_units - 16'd1;
                        if (len != 16'd0) begin
                            n_payload = len;
                            n_phase   = PH_PAYLOAD;
                        end else begin
                            do_next = 1'b1;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_payload = n_payload - 16'd1;
                    if (n_payload == 16'd0) begin
                        do_next = 1'b1;
                    end
                end
                default: begin
                    n_halted = 1'b1;
                    n_phase  = PH_IDLE;
                end
            endcase

            if (do_next) begin
                if (n_units != 16'd0) begin
                    n_phase = PH_LEN_HI;
                end else begin
                    do_end = 1'b1;
                end
            end

            if (do_end) begin
                n_arrays = n_arrays - 8'd1;
                if (n_arrays != 8'd0) begin
                    n_phase = PH_ARRAY;
                end else begin
                    slots[cnt[1:0]] = mk_event(EV_DONE);
                    cnt             = cnt + 3'd1;
                    n_halted        = 1'b1;
                    n_phase         = PH_IDLE;
                end
            end

            // A record that ends before parsing finishes. Results beyond four are dropped.
            if (!n_halted && nxt >= i_record_length) begin
                if (cnt < 3'(MAX_RESULTS)) begin
                    slots[cnt[1:0]] = mk_event(EV_TRUNC);
                    cnt             = cnt + 3'd1;
                end
                n_halted = 1'b1;
                n_phase  = PH_IDLE;
            end
        end

        if (cnt != 3'd0) begin
            last_ix                  = cnt - 3'd1;
            slots[last_ix[1:0]].last = 1'b1;
        end

        o_push   = i_accept && (cnt != 3'd0);
        o_bundle = slots;
    end

endmodule

`default_nettype wire

// ===== design/hcrp_queue.sv =====
// Short queue of result bundles between the parsing front and the back.
// Depends on hcrp_pkg for the bundle type and the queue depth.
`default_nettype none

module hcrp_queue
    import hcrp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_bundle i_bundle,
    output logic         o_ready,
    input  wire logic    i_pop,
    output logic         o_valid,
    output t_bundle      o_head
);

    t_bundle                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]       r_wr_ptr;
    logic [QUEUE_AW-1:0]       r_rd_ptr;
    logic [QUEUE_CW-1:0]       r_count;
    logic                      do_push;
    logic                      do_pop;

    assign o_ready = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/hcrp_back.sv =====
// Result back: hands out the results of the bundle at the queue head one per
// request, and releases the bundle after its last result. Depends on hcrp_pkg.
`default_nettype none

module hcrp_back
    import hcrp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_head_valid,
    input  wire t_bundle i_head,
    output logic         o_pop,
    output logic         o_res_valid,
    input  wire logic    i_res_ready,
    output t_res         o_res
);

    logic [$clog2(MAX_RESULTS)-1:0] r_idx;
    logic                           take;

    assign o_res_valid = i_head_valid;
    assign o_res       = i_head[r_idx];
    assign take        = o_res_valid && i_res_ready;
    assign o_pop       = take && o_res.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= o_res.last ? '0 : r_idx + 1'b1;
        end
    end

endmodule

`default_nettype wire

// ===== design/hevc_config_record_parser.sv =====
// HEVC decoder configuration record parser, top level. Depends on hcrp_pkg,
// hcrp_front, hcrp_queue and hcrp_back.
//
// Write the record's total byte length on the configuration channel, then
// feed the record one byte per request with start_of_record set on its first
// byte. The block reports each header field as it completes (index and value,
// reserved bits skipped), each NAL unit with its array's type, payload offset
// and length, and then record-done; errors (record too short, unit count or
// unit length beyond the remaining bytes, truncated record) end the parse,
// and bytes are then ignored until the next start. Each result of a byte is a
// request of its own on the result channel, and the final one of a byte has
// last set. A byte request can be taken every cycle while the queue has room:
// the front parses the byte in the cycle it is accepted and places its results
// in a two-entry queue, and the back hands them out one per cycle while the
// result channel is ready. A byte has as many results as it causes (none for
// most payload bytes, up to four for a few header bytes); the sustained rate
// is one byte per cycle whenever the results average at most one per byte,
// and otherwise it is set by the single result port. The length register may
// be written whenever the block is idle; its write channel is always ready.
`default_nettype none

module hevc_config_record_parser
    import hcrp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_req_valid,
    output logic             o_req_ready,
    input  wire t_in_req     i_req,
    output logic             o_res_valid,
    input  wire logic        i_res_ready,
    output t_res             o_res
);

    logic [15:0] r_record_length;
    logic        req_accept;
    logic        push;
    t_bundle     push_bundle;
    logic        pop;
    logic        head_valid;
    t_bundle     head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_record_length <= i_cfg_data;
        end
    end

    // The front parses a byte only when the queue has room for its results.
    assign req_accept = i_req_valid && o_req_ready;

    hcrp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_record_length (r_record_length),
        .i_accept        (req_accept),
        .i_req           (i_req),
        .o_push          (push),
        .o_bundle        (push_bundle)
    );

    hcrp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .o_ready  (o_req_ready),
        .i_pop    (pop),
        .o_valid  (head_valid),
        .o_head   (head)
    );

    hcrp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_res        (o_res)
    );

    // A start byte with a too-short length always leaves a result waiting.
    a_short_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_accept && i_req.start_of_record && (r_record_length < MIN_RECORD_BYTES))
        |=> o_res_valid)
        else $error("too-short record produced no result");

    // Only field results carry a field index and value.
    a_field_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.event_res != EV_FIELD))
        |-> ((o_res.field_id == '0) && (o_res.field_value == '0)))
        else $error("field data on a non-field result");

    // An error ends the parse, so it is always the final result of its byte.
    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && ((o_res.event_res == EV_SHORT) || (o_res.event_res == EV_COUNT)
            || (o_res.event_res == EV_LENGTH) || (o_res.event_res == EV_TRUNC)))
        |-> o_res.last)
        else $error("error result not marked last");

endmodule

`default_nettype wire
